>>> rtl/mafhp_pkg.sv
// Package for the MPEG audio frame header parser.
// Holds parse phase codes, output kinds, header decode helpers and rate tables.
// No dependencies.
`timescale 1ns / 1ps
package mafhp_pkg;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_TAG  = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_CRC  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LAST = 2'd1;
	localparam logic [1:0] KIND_HDR  = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef struct packed {
		logic       ver;
		logic [1:0] layer;
		logic       crc;
		logic [3:0] bi;
		logic [1:0] ri;
		logic       pad;
		logic [1:0] mode;
		logic [1:0] ext;
		logic       bad;
		logic [5:0] sb;
		logic [5:0] bound;
	} hdr_t;

	function automatic logic [8:0] kbps(input logic ver, input logic [1:0] layer,
			input logic [3:0] bi);
		logic [8:0] r;
		r = 9'd0;
		if (!ver) begin
			unique case (layer)
				2'd1: r = (bi == 4'd15) ? 9'd0 : 9'(32 * bi);
				2'd2: begin
					unique case (bi)
						4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
						4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
						4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd160;
						4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
						4'd13: r = 9'd320; 4'd14: r = 9'd384;
						default: r = 9'd0;
					endcase
				end
				default: begin
					unique case (bi)
						4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
						4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
						4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
						4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
						4'd13: r = 9'd256; 4'd14: r = 9'd320;
						default: r = 9'd0;
					endcase
				end
			endcase
		end else if (layer == 2'd1) begin
			unique case (bi)
				4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
				4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
				4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd144;
				4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
				4'd13: r = 9'd224; 4'd14: r = 9'd256;
				default: r = 9'd0;
			endcase
		end else begin
			unique case (bi)
				4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
				4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
				4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
				4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
				4'd13: r = 9'd144; 4'd14: r = 9'd160;
				default: r = 9'd0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [16:0] rate_hz(input logic ver, input logic [1:0] ri);
		logic [16:0] r;
		unique case (ri)
			2'd0: r = 17'd44100;
			2'd1: r = 17'd48000;
			default: r = 17'd32000;
		endcase
		return ver ? (r >> 1) : r;
	endfunction

	function automatic hdr_t decode(input logic [31:0] h);
		hdr_t d;
		logic signed [5:0] cbi;
		logic [5:0] b4;
		d.ver   = !h[19];
		unique case (h[18:17])
			2'd1: d.layer = 2'd3;
			2'd2: d.layer = 2'd2;
			2'd3: d.layer = 2'd1;
			default: d.layer = 2'd0;
		endcase
		d.crc   = !h[16];
		d.bi    = h[15:12];
		d.ri    = h[11:10];
		d.pad   = h[9];
		d.mode  = h[7:6];
		d.ext   = h[5:4];
		d.bad   = (d.layer == 2'd0) || (d.bi == 4'd0) || (d.bi == 4'd15) || (d.ri == 2'd3);
		cbi = $signed({2'b00, d.bi});
		if (d.mode != 2'd3)
			cbi = (d.bi == 4'd4) ? 6'sd1 : cbi - 6'sd4;
		if (d.layer == 2'd1)
			d.sb = 6'd32;
		else if (cbi == 6'sd1 || cbi == 6'sd2)
			d.sb = (d.ri == 2'd2) ? 6'd12 : 6'd8;
		else
			d.sb = (d.ri == 2'd1 || (cbi >= 6'sd3 && cbi <= 6'sd5)) ? 6'd27 : 6'd30;
		b4 = {2'b00, d.ext, 2'b00} + 6'd4;
		if (d.mode == 2'd3)
			d.bound = 6'd0;
		else if (d.mode == 2'd1)
			d.bound = (b4 > d.sb) ? d.sb : b4;
		else
			d.bound = d.sb;
		return d;
	endfunction

endpackage

>>> rtl/mpeg_audio_frame_header_parser_top.sv
// Top level of the MPEG audio frame header parser.
// Sync hunt, tag skip, header decode with a bit-serial divider; uses mafhp_pkg.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | byte_in
// out     | output    | out_valid/out_stall | kind, byte_value, header fields
//
// Every stream byte takes one cycle while the output slot is free, except a byte that
// completes a good header. That byte loads the divider; the restoring divider then forms
// the frame length one quotient bit per cycle, and a finish step presents the record.
// The result register takes a new item while the previous one leaves.
// Reset clears all control state; payload registers are not reset.
`timescale 1ns / 1ps
module mpeg_audio_frame_header_parser_top import mafhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic        mpeg_version,
	output logic [1:0]  layer_number,
	output logic        crc_present,
	output logic [3:0]  bitrate_index,
	output logic [1:0]  rate_index,
	output logic [1:0]  channel_mode,
	output logic [5:0]  subband_count,
	output logic [5:0]  stereo_bound,
	output logic [10:0] frame_bytes,
	output logic [10:0] layer3_slots
);

	state_t      state_q;
	logic [31:0] hs_q, hdr_q;
	logic [2:0]  ph_q, tcnt_q;
	logic [27:0] skip_q;
	logic [10:0] pay_q;
	logic [1:0]  crc_q;
	logic [25:0] num_q;
	logic [16:0] div_q, rem_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;

	logic        acc, slot_free, out_set;
	logic [31:0] hs_sh, th, hs_n;
	logic [2:0]  ph_n, tcnt_n;
	logic [27:0] skip_n, len;
	logic [1:0]  crc_n;
	logic [10:0] pay_n;
	logic        emit_data, emit_last, emit_bad, go_div;
	hdr_t        td, fd;
	logic [2:0]  tc1;
	logic [8:0]  td_kb;
	logic [16:0] td_hz;

	logic [17:0] rem_sh;
	logic        ge;
	logic [12:0] q1, fb, sub_s, sub_p;
	logic [5:0]  side;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !slot_free;
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	assign hs_sh = {hs_q[23:0], byte_in};
	assign tc1   = tcnt_q + 3'd1;
	assign len   = {hs_sh[30:24], hs_sh[22:16], hs_sh[14:8], hs_sh[6:0]};

	always_comb begin
		hs_n = hs_q; ph_n = ph_q; tcnt_n = tcnt_q; skip_n = skip_q;
		crc_n = crc_q; pay_n = pay_q;
		emit_data = 1'b0; emit_last = 1'b0; emit_bad = 1'b0; go_div = 1'b0;
		th = hs_sh;
		unique case (ph_q)
			PH_TAG: begin
				hs_n = hs_sh;
				if (byte_in == 8'hff) begin
					ph_n = PH_HUNT;
				end else begin
					tcnt_n = tc1;
					if (tc1 >= 3'd6) begin
						tcnt_n = 3'd0;
						hs_n = 32'd0;
						skip_n = len;
						ph_n = (len != 28'd0) ? PH_SKIP : PH_HUNT;
					end
				end
			end
			PH_SKIP: begin
				if (skip_q != 28'd0)
					skip_n = skip_q - 28'd1;
				if (skip_n == 28'd0) begin
					ph_n = PH_HUNT;
					hs_n = 32'd0;
				end
			end
			PH_CRC: begin
				if (crc_q != 2'd0)
					crc_n = crc_q - 2'd1;
				if (crc_n == 2'd0)
					ph_n = PH_DATA;
			end
			PH_DATA: begin
				emit_data = 1'b1;
				if (pay_q != 11'd0)
					pay_n = pay_q - 11'd1;
				if (pay_n == 11'd0) begin
					emit_last = 1'b1;
					ph_n = PH_HUNT;
					hs_n = 32'd0;
				end
			end
			default: begin
				ph_n = PH_HUNT;
				hs_n = hs_sh;
			end
		endcase
		if (ph_n == PH_HUNT && (ph_q == PH_HUNT || ph_q > PH_DATA ||
				(ph_q == PH_TAG && byte_in == 8'hff))) begin
			if (&th[31:20]) begin
				if (td.bad) begin
					emit_bad = 1'b1;
				end else begin
					go_div = 1'b1;
					hs_n = 32'd0;
				end
			end else if (th[31:24] == 8'h49 && th[23:16] == 8'h44 &&
					th[15:8] == 8'h33 && th[7:0] != 8'hff) begin
				ph_n = PH_TAG;
				tcnt_n = 3'd0;
			end
		end
	end

	assign td    = decode(hs_sh);
	assign fd    = decode(hdr_q);
	assign td_kb = kbps(td.ver, td.layer, td.bi);
	assign td_hz = rate_hz(td.ver, td.ri);

	assign rem_sh = {rem_q, num_q[25]};
	assign ge     = rem_sh >= {1'b0, div_q};

	assign out_set = (state_q == ST_IDLE && acc && (emit_data || emit_bad)) ||
			(state_q == ST_FIN && slot_free);

	always_comb begin
		q1    = {2'b00, num_q[10:0]} + {12'd0, fd.pad};
		fb    = (fd.layer == 2'd1) ? {q1[10:0], 2'b00} : q1;
		side  = fd.ver ? ((fd.mode == 2'd3) ? 6'd9 : 6'd17) :
				((fd.mode == 2'd3) ? 6'd17 : 6'd32);
		sub_p = 13'd4 + {10'd0, fd.crc, 1'b0};
		sub_s = sub_p + {7'd0, side};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hs_q <= 32'd0; ph_q <= PH_HUNT; tcnt_q <= 3'd0;
			skip_q <= 28'd0; pay_q <= 11'd0; crc_q <= 2'd0;
			cnt_q <= 5'd0; out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						hs_q <= hs_n; ph_q <= ph_n; tcnt_q <= tcnt_n;
						skip_q <= skip_n; crc_q <= crc_n; pay_q <= pay_n;
						if (go_div) begin
							state_q <= ST_DIV;
							cnt_q <= 5'd0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd25)
						state_q <= ST_FIN;
				end
				default: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (fb <= sub_p) begin
							ph_q <= PH_HUNT;
						end else begin
							pay_q <= 11'(fb - sub_p);
							crc_q <= {fd.crc, 1'b0};
							ph_q <= fd.crc ? PH_CRC : PH_DATA;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc && go_div) begin
			hdr_q <= hs_sh;
			rem_q <= 17'd0;
			num_q <= (td.layer == 2'd1) ? 26'd12000 * {17'd0, td_kb}
					: 26'd144000 * {17'd0, td_kb};
			div_q <= (td.ver && td.layer == 2'd3) ? {td_hz[15:0], 1'b0} : td_hz;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? 17'(rem_sh - {1'b0, div_q}) : rem_sh[16:0];
			num_q <= {num_q[24:0], ge};
		end
		if (state_q == ST_IDLE && acc && (emit_data || emit_bad)) begin
			kind <= emit_bad ? KIND_BAD : (emit_last ? KIND_LAST : KIND_DATA);
			byte_value <= emit_bad ? 8'd0 : byte_in;
			mpeg_version  <= emit_bad ? td.ver : 1'b0;
			layer_number  <= emit_bad ? td.layer : 2'd0;
			crc_present   <= emit_bad ? td.crc : 1'b0;
			bitrate_index <= emit_bad ? td.bi : 4'd0;
			rate_index    <= emit_bad ? td.ri : 2'd0;
			channel_mode  <= emit_bad ? td.mode : 2'd0;
			subband_count <= 6'd0;
			stereo_bound  <= 6'd0;
			frame_bytes   <= 11'd0;
			layer3_slots  <= 11'd0;
		end else if (state_q == ST_FIN && slot_free) begin
			kind <= KIND_HDR;
			byte_value <= 8'd0;
			mpeg_version  <= fd.ver;
			layer_number  <= fd.layer;
			crc_present   <= fd.crc;
			bitrate_index <= fd.bi;
			rate_index    <= fd.ri;
			channel_mode  <= fd.mode;
			subband_count <= fd.sb;
			stereo_bound  <= fd.bound;
			frame_bytes   <= fb[10:0];
			layer3_slots  <= (fd.layer == 2'd3 && fb > sub_s) ? 11'(fb - sub_s) : 11'd0;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register lost its one-hot code");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> in_stall)
		else $error("input taken while the divider runs");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && slot_free) |=> (out_valid && kind == KIND_HDR))
		else $error("header record not presented after the division");

endmodule
